FILE: hdl/ltl_pkg.sv
`default_nettype none
package ltl_pkg;

  // lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_NAME    = 3'd2;
  localparam logic [2:0] MODE_ATTR    = 3'd3;
  localparam logic [2:0] MODE_STOPPED = 3'd4;

  // token kinds
  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_ATTR  = 3'd1;
  localparam logic [2:0] KIND_OPEN  = 3'd2;
  localparam logic [2:0] KIND_CLOSE = 3'd3;
  localparam logic [2:0] KIND_EQUAL = 3'd4;
  localparam logic [2:0] KIND_SEMI  = 3'd5;

  // characters
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_PRINT_LO = 8'd33;
  localparam logic [7:0] CH_DEL     = 8'd127;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_IDX_W + 1;

  typedef struct packed {
    logic [2:0] token_kind;
    logic       has_char;
    logic [7:0] char_value;
    logic       starts_token;
    logic       ends_token;
    logic       bad_byte;
    logic       open_attribute_at_end;
    logic       last_of_run;
  } result_t;

  // one queue entry holds all results of one input transaction
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

FILE: hdl/ltl_ifs.sv
`default_nettype none
interface ltl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, text_byte, end_of_input, input ready);
  modport sink   (input valid, text_byte, end_of_input, output ready);
endinterface

interface ltl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic       has_char;
  logic [7:0] char_value;
  logic       starts_token;
  logic       ends_token;
  logic       bad_byte;
  logic       open_attribute_at_end;
  logic       last_of_run;

  modport source (output valid, token_kind, has_char, char_value, starts_token,
                  ends_token, bad_byte, open_attribute_at_end, last_of_run,
                  input ready);
  modport sink   (input valid, token_kind, has_char, char_value, starts_token,
                  ends_token, bad_byte, open_attribute_at_end, last_of_run,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/ltl_front.sv
`default_nettype none
module ltl_front
  import ltl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  ltl_in_if.sink      in_ch,
  input  wire q_stat_t q_stat,
  output logic        q_push,
  output q_entry_t    q_entry
);

  logic [2:0] mode_r, mode_nxt;
  logic       accept;
  logic       v0, v1;
  result_t    r0, r1;

  function automatic logic is_name_byte(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_USCORE);
  endfunction

  // byte lexed from idle: result flag, result, mode after
  typedef struct packed {
    logic       v;
    result_t    r;
    logic [2:0] mode;
  } idle_lex_t;

  function automatic idle_lex_t lex_idle(input logic [7:0] c);
    idle_lex_t o;
    o      = '0;
    o.mode = MODE_IDLE;
    if (c == CH_NL || (c != CH_NUL && (c < CH_PRINT_LO || c > CH_DEL))) begin
      o.v = 1'b0;
    end else if (c == CH_HASH) begin
      o.mode = MODE_COMMENT;
    end else if (is_name_byte(c)) begin
      o.v = 1'b1; o.mode = MODE_NAME;
      o.r.token_kind = KIND_NAME; o.r.has_char = 1'b1;
      o.r.char_value = c; o.r.starts_token = 1'b1;
    end else if (c == CH_QUOTE) begin
      o.v = 1'b1; o.mode = MODE_ATTR;
      o.r.token_kind = KIND_ATTR; o.r.has_char = 1'b1;
      o.r.char_value = c; o.r.starts_token = 1'b1;
    end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_EQUAL || c == CH_SEMI) begin
      o.v = 1'b1;
      o.r.token_kind = (c == CH_LBRACE) ? KIND_OPEN  :
                       (c == CH_RBRACE) ? KIND_CLOSE :
                       (c == CH_EQUAL)  ? KIND_EQUAL : KIND_SEMI;
      o.r.has_char = 1'b1; o.r.char_value = c;
      o.r.starts_token = 1'b1; o.r.ends_token = 1'b1;
    end else begin
      o.v = 1'b1; o.mode = MODE_STOPPED;
      o.r.bad_byte = 1'b1;
    end
    return o;
  endfunction

  idle_lex_t idl;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign idl         = lex_idle(in_ch.text_byte);

  always_comb begin
    v0 = 1'b0; v1 = 1'b0;
    r0 = '0;   r1 = '0;
    mode_nxt = mode_r;
    if (mode_r == MODE_STOPPED) begin
      mode_nxt = MODE_STOPPED;
    end else if (in_ch.end_of_input) begin
      if (mode_r == MODE_NAME) begin
        v0 = 1'b1; r0.token_kind = KIND_NAME; r0.ends_token = 1'b1;
      end else if (mode_r == MODE_ATTR) begin
        v0 = 1'b1; r0.token_kind = KIND_ATTR; r0.open_attribute_at_end = 1'b1;
      end
      mode_nxt = MODE_IDLE;
    end else begin
      unique case (mode_r)
        MODE_COMMENT: begin
          if (in_ch.text_byte == CH_NL) mode_nxt = MODE_IDLE;
        end
        MODE_NAME: begin
          v0 = 1'b1;
          r0.token_kind = KIND_NAME;
          if (is_name_byte(in_ch.text_byte)) begin
            r0.has_char = 1'b1; r0.char_value = in_ch.text_byte;
          end else begin
            // end marker, then the terminating byte lexed from idle
            r0.ends_token = 1'b1;
            v1 = idl.v; r1 = idl.r; mode_nxt = idl.mode;
          end
        end
        MODE_ATTR: begin
          v0 = 1'b1;
          r0.token_kind = KIND_ATTR; r0.has_char = 1'b1;
          r0.char_value = in_ch.text_byte;
          if (in_ch.text_byte == CH_QUOTE) begin
            r0.ends_token = 1'b1; mode_nxt = MODE_IDLE;
          end
        end
        default: begin
          v0 = idl.v; r0 = idl.r; mode_nxt = idl.mode;
        end
      endcase
    end
    if (v1) r1.last_of_run = 1'b1;
    else    r0.last_of_run = 1'b1;
  end

  assign q_push     = accept && v0;
  assign q_entry.two = v1;
  assign q_entry.r0  = r0;
  assign q_entry.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_STOPPED) |=> (mode_r == MODE_STOPPED))
    else $error("stopped lexer left stopped mode");

  a_two_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && v1) |-> (v0 && r0.ends_token && r0.token_kind == KIND_NAME))
    else $error("second result without name end marker");

endmodule
`default_nettype wire

FILE: hdl/ltl_queue.sv
`default_nettype none
module ltl_queue
  import ltl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_stat_t       stat
);

  q_entry_t             mem [Q_DEPTH];
  logic [Q_IDX_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: hdl/ltl_back.sv
`default_nettype none
module ltl_back
  import ltl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_entry_t head,
  input  wire q_stat_t  q_stat,
  output logic          pop,
  ltl_out_if.source     out_ch
);

  result_t out_r, hold_r;
  logic    out_valid_r, hold_valid_r;
  logic    load;

  // output register may take a new result when empty or being drained
  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && !hold_valid_r && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (load) begin
      if (hold_valid_r) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= !q_stat.empty;
        hold_valid_r <= !q_stat.empty && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid_r) begin
        out_r <= hold_r;
      end else begin
        out_r  <= head.r0;
        hold_r <= head.r1;
      end
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.token_kind            = out_r.token_kind;
  assign out_ch.has_char              = out_r.has_char;
  assign out_ch.char_value            = out_r.char_value;
  assign out_ch.starts_token          = out_r.starts_token;
  assign out_ch.ends_token            = out_r.ends_token;
  assign out_ch.bad_byte              = out_r.bad_byte;
  assign out_ch.open_attribute_at_end = out_r.open_attribute_at_end;
  assign out_ch.last_of_run           = out_r.last_of_run;

  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> (out_valid_r && !out_r.last_of_run))
    else $error("held second result without a pending first");

endmodule
`default_nettype wire

FILE: hdl/map_text_token_lexer.sv
// Map text token lexer.
// in_ch  : one transaction per byte of map text (text_byte), or an end of
//          text marker (end_of_input set, byte ignored). valid/ready handshake.
// out_ch : token results, one per transaction; last_of_run marks the final
//          result caused by one input transaction. An input gives 0, 1 or 2.
// Structure: a front end classifies each byte and keeps the lexer mode, a
// four-entry queue holds the results per input, and a back end feeds them
// through a registered output with a one-result hold for the second result.
// Path: results of an accepted input go into the queue, then from its head
// into the output register, which holds them until the receiver takes them.
// Throughput: one input per cycle while the queue has room; the output moves
// one result per cycle while the receiver is ready, so a name ended by a
// token byte gives two output results.
// Receiver stall: the output register holds its result; the queue fills,
// and in_ch.ready falls once all four entries are in use.
// Reset (rst_n low, synchronous): queue and output emptied, lexer idle.
// A bad byte stops the lexer; later input is taken and yields nothing until
// reset.
`default_nettype none
module map_text_token_lexer
  import ltl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ltl_in_if.sink    in_ch,
  ltl_out_if.source out_ch
);

  q_entry_t push_entry, head;
  q_stat_t  q_stat;
  logic     push, pop;

  // front: classification and mode register
  ltl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (push),
    .q_entry (push_entry)
  );

  // decoupling queue, one entry per input transaction with results
  ltl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // back: splits entries into single result transactions
  ltl_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
